@@ src/sof_pkg.sv @@
// Shared constants, codes and handshake structs of the second-order oscillator filter.
// No dependencies; imported by every module of the block.
`default_nettype none
package sof_pkg;

   localparam int DATA_W    = 32;
   localparam int COEF_FRAC = 30;
   localparam int NF_W      = 32;
   localparam int ZETA_W    = 17;
   localparam int DT_W      = 32;
   localparam int X_W       = 48;
   localparam int WIDE_W    = 98;
   localparam int NORM_W    = 32;
   localparam int QUOT_W    = 32;
   localparam int NUM_W     = 63;
   localparam int MUL_W     = 34;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int ACC_W     = 68;

   localparam logic [NF_W-1:0]   NF_RESET = 32'h0001_0000;
   localparam logic [ZETA_W-1:0] ZETA_ONE = 17'h1_0000;

   typedef enum logic [0:0] {
      CSR_NATURAL_FREQ  = 1'b0,
      CSR_DAMPING_RATIO = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      FUNC_UPDATE = 1'b0,
      FUNC_PRESET = 1'b1
   } func_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [NORM_W-1:0] den;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

@@ src/sof_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on sof_pkg.
`default_nettype none
module sof_mul
   import sof_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [MUL_W-1:0]  op_a,
   input  wire logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0]      prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule
`default_nettype wire

@@ src/sof_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on sof_pkg.
`default_nettype none
module sof_div
   import sof_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire div_ctrl_type ctrl,
   output div_status_type    status,
   output logic [QUOT_W-1:0] quot
);

   logic [NUM_W-1:0]  num_ff;
   logic [NORM_W-1:0] rem_ff;
   logic [NORM_W-1:0] den_ff;
   logic [5:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [NORM_W:0]   part;
   logic [NORM_W:0]   trial;

   assign part  = {rem_ff, num_ff[NUM_W-1]};
   assign trial = part - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            num_ff  <= ctrl.num;
            den_ff  <= ctrl.den;
            rem_ff  <= '0;
            cnt_ff  <= 6'(NUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!trial[NORM_W]) begin
               rem_ff <= trial[NORM_W-1:0];
               num_ff <= {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= part[NORM_W-1:0];
               num_ff <= {num_ff[NUM_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = num_ff[QUOT_W-1:0];

endmodule
`default_nettype wire

@@ src/second_order_oscillator_filter.sv @@
// Top level of the second-order oscillator filter: sequencer, state and result register.
// Depends on sof_pkg, sof_mul and sof_div.
`default_nettype none
// Bilinear second-order lowpass w^2/(s^2+2zws+w^2), recomputing its biquad
// coefficients from natural_freq, damping_ratio and the per-item time step.
// One item is worked at a time; req_stall is high until it finishes. A preset or a
// zero time step skips the arithmetic. An update runs 11 products on one shared 34x34
// multiplier, a normalizing right shift of one bit per cycle, and three passes
// through one restoring divider (63 quotient bits each), which dominate the run time.
// A finished result sits in the output register, so the next item may transfer in
// while it waits. Damping writes whose low 17 bits exceed 1.0 clamp to 1.0.
module second_order_oscillator_filter
   import sof_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_func,
   input  wire logic signed [DATA_W-1:0] req_sample_in,
   input  wire logic [DT_W-1:0]          req_time_step,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_value_out,
   output logic                          rsp_updated,
   input  wire logic                     csr_we,
   input  wire logic [0:0]               csr_index,
   input  wire logic [NF_W-1:0]          csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_ACC, ST_DE, ST_NORM, ST_DIV_GO, ST_DIV_WAIT, ST_ROUND, ST_FIN
   } state_type;

   state_type               state_ff;
   logic [3:0]              step_ff;
   logic [1:0]              div_idx_ff;
   logic [NF_W-1:0]         nf_ff;
   logic [ZETA_W-1:0]       z_ff;
   logic signed [DATA_W-1:0] u_ff, u1_ff, u2_ff, y1_ff, y2_ff;
   logic [DT_W-1:0]         dt_ff;
   logic [X_W-1:0]          x_ff;
   logic [WIDE_W-1:0]       a_ff, b_ff, d_ff, e_ff;
   logic [51:0]             f_ff;
   logic [QUOT_W-1:0]       ca_ff, q8_ff, cd_ff;
   logic signed [ACC_W-1:0] facc_ff;
   logic signed [DATA_W-1:0] res_value_ff, rsp_value_ff;
   logic                    res_upd_ff, rsp_upd_ff, rsp_valid_ff;

   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [MUL_W-1:0]  coef_a, coef_b, coef_c, coef_d;
   logic [32:0]              num_sel;
   div_ctrl_type             div_ctrl;
   div_status_type           div_status;
   logic [QUOT_W-1:0]        quot;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [DATA_W-1:0] y_sat;
   logic                     req_xfer;

   sof_mul u_mul (.clock(clock), .op_a(op_a), .op_b(op_b), .prod_ff(prod));
   sof_div u_div (.clock(clock), .reset(reset), .ctrl(div_ctrl), .status(div_status),
                  .quot(quot));

   assign req_xfer = req_valid && !req_stall;

   // coefficients: cb = 2*ca, cc = 2*ca - q8
   assign coef_a = signed'({2'b00, ca_ff});
   assign coef_b = signed'({1'b0, ca_ff, 1'b0});
   assign coef_c = coef_b - signed'({2'b00, q8_ff});
   assign coef_d = signed'({2'b00, cd_ff});

   // operand select for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         4'd0: begin op_a = signed'({2'b00, nf_ff}); op_b = signed'({2'b00, dt_ff}); end
         4'd1: begin op_a = signed'(MUL_W'(x_ff[23:0]));  op_b = signed'(MUL_W'(x_ff[23:0])); end
         4'd2: begin op_a = signed'(MUL_W'(x_ff[47:24])); op_b = signed'(MUL_W'(x_ff[23:0])); end
         4'd3: begin op_a = signed'(MUL_W'(x_ff[47:24])); op_b = signed'(MUL_W'(x_ff[47:24])); end
         4'd4: begin op_a = signed'(MUL_W'(z_ff)); op_b = signed'(MUL_W'(x_ff[23:0])); end
         4'd5: begin op_a = signed'(MUL_W'(z_ff)); op_b = signed'(MUL_W'(x_ff[47:24])); end
         4'd6: begin op_a = coef_a; op_b = MUL_W'(u_ff); end
         4'd7: begin op_a = coef_b; op_b = MUL_W'(u1_ff); end
         4'd8: begin op_a = coef_a; op_b = MUL_W'(u2_ff); end
         4'd9: begin op_a = coef_c; op_b = MUL_W'(y1_ff); end
         4'd10: begin op_a = coef_d; op_b = MUL_W'(y2_ff); end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   // dividend: normalized A, F or E, scaled up by the coefficient fraction
   always_comb begin
      case (div_idx_ff)
         2'd0:    num_sel = a_ff[32:0];
         2'd1:    num_sel = f_ff[32:0];
         default: num_sel = e_ff[32:0];
      endcase
   end

   assign div_ctrl.start = (state_ff == ST_DIV_GO);
   assign div_ctrl.num   = {num_sel[NUM_W-COEF_FRAC-1:0], {COEF_FRAC{1'b0}}};
   assign div_ctrl.den   = d_ff[NORM_W-1:0];

   // round half up, floor shift, saturate
   assign rnd = facc_ff + ACC_W'(64'd1 << (COEF_FRAC - 1));
   always_comb begin
      if (!rnd[ACC_W-1] && rnd[ACC_W-2:COEF_FRAC+DATA_W-1] != '0)
         y_sat = {1'b0, {(DATA_W-1){1'b1}}};
      else if (rnd[ACC_W-1] && rnd[ACC_W-2:COEF_FRAC+DATA_W-1] != '1)
         y_sat = {1'b1, {(DATA_W-1){1'b0}}};
      else
         y_sat = rnd[COEF_FRAC+DATA_W-1:COEF_FRAC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         div_idx_ff   <= '0;
         nf_ff        <= NF_RESET;
         z_ff         <= '0;
         u1_ff        <= '0;
         u2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_NATURAL_FREQ:  nf_ff <= csr_wdata;
               CSR_DAMPING_RATIO: z_ff <= (csr_wdata[ZETA_W-1:0] > ZETA_ONE) ?
                                          ZETA_ONE : csr_wdata[ZETA_W-1:0];
               default: ;
            endcase
         end
         // output slot: load a finished result, else drain on transfer
         if (state_ff == ST_FIN && (!rsp_valid_ff || !rsp_stall))
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  u_ff  <= req_sample_in;
                  dt_ff <= req_time_step;
                  if (func_type'(req_func) == FUNC_PRESET) begin
                     y1_ff        <= req_sample_in;
                     y2_ff        <= req_sample_in;
                     res_value_ff <= req_sample_in;
                     res_upd_ff   <= 1'b1;
                     state_ff     <= ST_FIN;
                  end else if (req_time_step == '0) begin
                     res_value_ff <= y1_ff;
                     res_upd_ff   <= 1'b0;
                     state_ff     <= ST_FIN;
                  end else begin
                     step_ff  <= '0;
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: state_ff <= ST_ACC;
            ST_ACC: begin
               case (step_ff)
                  4'd0: x_ff <= prod[X_W+15:16];
                  4'd1: a_ff <= WIDE_W'(prod[47:0]);
                  4'd2: a_ff <= a_ff + (WIDE_W'(prod[47:0]) << 25);
                  4'd3: a_ff <= a_ff + (WIDE_W'(prod[47:0]) << 48);
                  4'd4: b_ff <= WIDE_W'(prod[40:0]) << 10;
                  4'd5: b_ff <= b_ff + (WIDE_W'(prod[40:0]) << 34);
                  4'd6: facc_ff <= prod;
                  4'd7, 4'd8: facc_ff <= facc_ff + prod;
                  4'd9, 4'd10: facc_ff <= facc_ff - prod;
                  default: ;
               endcase
               if (step_ff == 4'd5)
                  state_ff <= ST_DE;
               else if (step_ff == 4'd10)
                  state_ff <= ST_ROUND;
               else begin
                  step_ff  <= step_ff + 4'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_DE: begin
               // D = 4 + B + A, E = 4 - B + A, F = 8, all at scale 2^48
               d_ff     <= a_ff + b_ff + (WIDE_W'(1) << 50);
               e_ff     <= a_ff - b_ff + (WIDE_W'(1) << 50);
               f_ff     <= 52'h1 << 51;
               state_ff <= ST_NORM;
            end
            ST_NORM: begin
               if (d_ff[WIDE_W-1:NORM_W] != '0) begin
                  a_ff <= a_ff >> 1;
                  d_ff <= d_ff >> 1;
                  e_ff <= e_ff >> 1;
                  f_ff <= f_ff >> 1;
               end else begin
                  div_idx_ff <= '0;
                  state_ff   <= ST_DIV_GO;
               end
            end
            ST_DIV_GO: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_status.done) begin
                  case (div_idx_ff)
                     2'd0:    ca_ff <= quot;
                     2'd1:    q8_ff <= quot;
                     default: cd_ff <= quot;
                  endcase
                  if (div_idx_ff == 2'd2) begin
                     step_ff  <= 4'd6;
                     state_ff <= ST_MUL;
                  end else begin
                     div_idx_ff <= div_idx_ff + 2'd1;
                     state_ff   <= ST_DIV_GO;
                  end
               end
            end
            ST_ROUND: begin
               u2_ff        <= u1_ff;
               u1_ff        <= u_ff;
               y2_ff        <= y1_ff;
               y1_ff        <= y_sat;
               res_value_ff <= y_sat;
               res_upd_ff   <= 1'b1;
               state_ff     <= ST_FIN;
            end
            ST_FIN: begin
               // output slot free or draining this cycle
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_value_ff <= res_value_ff;
                  rsp_upd_ff   <= res_upd_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_updated   = rsp_upd_ff;

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("block took a transfer but did not go busy");

   a_div_not_busy: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_status.busy)
      else $error("divider restarted while busy");

   a_norm_divisor: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> (d_ff[NORM_W-1] && d_ff[WIDE_W-1:NORM_W] == '0))
      else $error("divisor not normalized at divide start");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished result not loaded into free output slot");

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for second_order_oscillator_filter.
// Depends on sof_pkg and the RTL under src; predicts every output in-line.
`default_nettype none
module tb;
   import sof_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      func_type                  func;
      logic signed [DATA_W-1:0]  sample;
      logic [DT_W-1:0]           dt;
   } filter_item_t;

   typedef struct {
      logic signed [DATA_W-1:0]  value;
      logic                      updated;
   } filter_out_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_func = 1'b0;
   logic signed [DATA_W-1:0] req_sample_in = '0;
   logic [DT_W-1:0]          req_time_step = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_value_out;
   logic                     rsp_updated;
   logic                     csr_we = 1'b0;
   logic [0:0]               csr_index = '0;
   logic [NF_W-1:0]          csr_wdata = '0;

   second_order_oscillator_filter dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: configuration and filter history.
   logic [NF_W-1:0]          omega_q;
   logic [ZETA_W-1:0]        zeta_q;
   logic signed [DATA_W-1:0] u1_q, u2_q, y1_q, y2_q;

   filter_item_t pending_items[$];
   filter_out_t  expected_outs[$];

   int  sender_idle_pct = 0;
   int  receiver_idle_pct = 0;
   bit  hold_sender = 1'b0;
   int  mismatches = 0;
   int  quiet_cycles = 0;

   // Bilinear biquad step, exact at 128 bits.
   function automatic filter_out_t filter_step(filter_item_t it);
      filter_out_t r;
      logic [63:0]  x;
      logic [127:0] a, b, d, e, f;
      logic [63:0]  ds, num_a, num_f, num_e;
      int           nb, s;
      longint       ca, q8, cd, cb, cc;
      logic signed [127:0] w_ca, w_cb, w_cc, w_cd, w_u, w_u1, w_u2, w_y1, w_y2, acc, y;
      r.updated = 1'b0;
      if (it.func == FUNC_PRESET) begin
         y1_q = it.sample;
         y2_q = it.sample;
         r.updated = 1'b1;
      end else if (it.dt != 0) begin
         x = ({32'd0, omega_q} * {32'd0, it.dt}) >> 16;
         a = {64'd0, x} * {64'd0, x};
         b = {64'd0, 64'({47'd0, zeta_q} * x)} * 128'd1024;
         f = 128'd1 << 51;
         d = a + b + (128'd1 << 50);
         e = a - b + (128'd1 << 50);
         nb = 0;
         for (int i = 127; i >= 0; i--)
            if (nb == 0 && d[i]) nb = i + 1;
         s = (nb > 62 - COEF_FRAC) ? nb - (62 - COEF_FRAC) : 0;
         ds = 64'(d >> s);
         num_a = 64'(a >> s) << COEF_FRAC;
         num_f = 64'(f >> s) << COEF_FRAC;
         num_e = 64'(e >> s) << COEF_FRAC;
         ca = longint'(num_a / ds);
         q8 = longint'(num_f / ds);
         cd = longint'(num_e / ds);
         cb = 2 * ca;
         cc = cb - q8;
         w_ca = ca; w_cb = cb; w_cc = cc; w_cd = cd;
         w_u = it.sample; w_u1 = u1_q; w_u2 = u2_q; w_y1 = y1_q; w_y2 = y2_q;
         acc = w_ca * w_u + w_cb * w_u1 + w_ca * w_u2 - w_cc * w_y1 - w_cd * w_y2;
         acc = acc + (128'sd1 <<< (COEF_FRAC - 1));
         y = acc >>> COEF_FRAC;
         u2_q = u1_q;
         u1_q = it.sample;
         y2_q = y1_q;
         if (y > 128'sd2147483647)       y1_q = 32'sh7FFF_FFFF;
         else if (y < -128'sd2147483648) y1_q = 32'sh8000_0000;
         else                            y1_q = y[31:0];
         r.updated = 1'b1;
      end
      r.value = y1_q;
      return r;
   endfunction

   // Driver: note the transfer at the rising edge, pick the next item at the falling one.
   bit req_taken = 1'b0;
   always @(posedge clock) begin
      req_taken <= 1'b0;
      if (!reset && req_valid && !req_stall) begin
         expected_outs.push_back(filter_step(pending_items.pop_front()));
         req_taken <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_items.size() > 0 && !hold_sender &&
             $urandom_range(99) >= sender_idle_pct) begin
            req_valid     <= 1'b1;
            req_func      <= pending_items[0].func;
            req_sample_in <= pending_items[0].sample;
            req_time_step <= pending_items[0].dt;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // Monitor: compare every result transfer against the oldest expectation.
   always @(posedge clock) begin
      filter_out_t exp_o;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_value_out);
         end else begin
            exp_o = expected_outs.pop_front();
            if (rsp_value_out !== exp_o.value || rsp_updated !== exp_o.updated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: value %h/%h updated %b/%b (exp/act)",
                           exp_o.value, rsp_value_out, exp_o.updated, rsp_updated);
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic csr_write(csr_index_type idx, logic [NF_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_NATURAL_FREQ) omega_q = data;
      else zeta_q = (data[16:0] > ZETA_ONE) ? ZETA_ONE : data[16:0];
   endtask

   task automatic push_item(func_type fn, logic [31:0] smp, logic [31:0] dt);
      filter_item_t it;
      it.func = fn;
      it.sample = smp;
      it.dt = dt;
      pending_items.push_back(it);
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || expected_outs.size() > 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic push_random(int count);
      logic [31:0] smp, dt;
      int sel;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         smp = $urandom;
         if ($urandom_range(9) == 0) smp = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         else if ($urandom_range(2) == 0) smp = $signed(smp) >>> $urandom_range(20);
         dt = $urandom >> $urandom_range(31);
         if (sel < 5) dt = '0;
         push_item(sel >= 90 ? FUNC_PRESET : FUNC_UPDATE, smp, dt);
      end
   endtask

   initial begin
      logic [NF_W-1:0] omega_set[6];
      logic [NF_W-1:0] zeta_set[6];
      omega_set = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0064_0000,
                    32'h0000_0001, 32'h0010_0000};
      zeta_set  = '{32'h0001_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h0000_B505,
                    32'h0000_8000, 32'h0000_0001};
      omega_q = NF_RESET;
      zeta_q  = '0;
      u1_q = '0; u2_q = '0; y1_q = '0; y2_q = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset config, zero step, presets, field extremes, tiny w*dt.
      push_item(FUNC_UPDATE, 32'h0001_0000, 32'h0000_0000);
      push_item(FUNC_UPDATE, 32'h0001_0000, 32'h0040_0000);
      push_item(FUNC_UPDATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      push_item(FUNC_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF);
      push_item(FUNC_PRESET, 32'h7FFF_FFFF, 32'h0000_0000);
      push_item(FUNC_UPDATE, 32'h0000_0000, 32'h0000_0001);
      push_item(FUNC_UPDATE, 32'h0000_0000, 32'h0000_0001);
      push_item(FUNC_PRESET, 32'h8000_0000, 32'hFFFF_FFFF);
      push_item(FUNC_UPDATE, 32'h8000_0000, 32'h0000_0001);
      push_item(FUNC_PRESET, 32'h0000_0000, 32'h0100_0000);
      push_item(FUNC_UPDATE, 32'hFFFF_0000, 32'h0100_0000);
      push_item(FUNC_UPDATE, 32'h0000_0000, 32'h0000_0000);
      push_item(FUNC_UPDATE, 32'h0002_0000, 32'h0001_0000);
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         sender_idle_pct   = (ph % 3 == 0) ? 28 : (ph % 3 == 1) ? 83 : 0;
         receiver_idle_pct = (ph % 3 == 0) ? 83 : (ph % 3 == 1) ? 28 : 0;
         csr_write(CSR_NATURAL_FREQ, omega_set[ph]);
         csr_write(CSR_DAMPING_RATIO, zeta_set[ph]);
         if (ph == 0) begin
            push_item(FUNC_UPDATE, 32'h0001_0000, 32'h0100_0000);
            push_item(FUNC_UPDATE, 32'h0001_0000, 32'hFFFF_FFFF);
         end
         push_random(180);
         if (ph == 2) begin
            // Sender holds off until the block has returned everything.
            repeat (3000) @(posedge clock);
            hold_sender = 1'b1;
            while (expected_outs.size() > 0 || req_valid) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_drained();
      end

      repeat (400) @(posedge clock);
      if (mismatches == 0 && expected_outs.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
src/sof_pkg.sv
src/sof_mul.sv
src/sof_div.sv
src/second_order_oscillator_filter.sv
dv/tb.sv
